// ===== rtl/sva_pkg.sv =====
// ----------------------------------------------------------------------------
// Voice allocator package
// Shared widths, command and register codes, and the voice record type.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int MAX_VOICES_DEF    = 16;
  localparam int BUFFER_LENGTH_DEF = 65536;

  localparam int CMD_W    = 2;
  localparam int NOTE_W   = 7;
  localparam int PITCH_W  = 24;
  localparam int POS_W    = 16;
  localparam int ENDED_W  = 4;
  localparam int VIDX_W   = 4;
  localparam int AGE_W    = 32;
  localparam int POLICY_W = 2;
  localparam int USE_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  // Wide enough to hold the largest buffer length.
  localparam int BUF_CMP_W  = POS_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOTE_ON     = 2'd0,
    CMD_NOTE_OFF    = 2'd1,
    CMD_SAMPLE_TICK = 2'd2,
    CMD_VOICE_ENDED = 2'd3
  } cmd_e;

  typedef enum logic [POLICY_W-1:0] {
    POL_DROP          = 2'd0,
    POL_STEAL_OLDEST  = 2'd1,
    POL_STEAL_LOWEST  = 2'd2,
    POL_STEAL_HIGHEST = 2'd3
  } policy_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOICE_POLICY    = 2'd0,
    CFG_VOICES_IN_USE   = 2'd1,
    CFG_RELEASE_IS_ZERO = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [NOTE_W-1:0]  note;
    logic [PITCH_W-1:0] pitch;
    logic [POS_W-1:0]   start;
    logic [AGE_W-1:0]   age;
  } voice_rec_t;

endpackage

// ===== rtl/synth_voice_allocator.sv =====
// ----------------------------------------------------------------------------
// Synth voice allocator
// Polyphonic voice table with note-on allocation, voice stealing, sample-tick
// start and aging, note-off and envelope-end handling.
// ----------------------------------------------------------------------------
// Usage: commands enter on the in channel (valid/ready) and each one produces
// exactly one result transfer on the out channel (valid/ready). Only a granted
// note-on carries a nonzero result; every other command returns all zeros.
// Configuration writes use a separate cfg channel that is always ready and
// should be issued only while the block is idle.
// Timing: voice_ended and refused or trivial commands go from acceptance
// straight to the finish state, which loads the output register. note_on,
// sample_tick and an immediate note_off walk the records of the voices in use
// one per cycle through the record memory (one write and one registered read
// port); note_on then passes a commit state before the finish state.
// One command is in flight at a time; a new one is taken once the previous
// result has been placed in the output register, even if it is not yet taken.
// Reset clears all voice flags and loads policy 1, four voices and release
// off. Writing voices_in_use clears the voice flags again.
// If the receiver stalls, the result holds in the output register and the
// block waits before loading the next result.
// ----------------------------------------------------------------------------
module synth_voice_allocator #(
  parameter int MAX_VOICES    = sva_pkg::MAX_VOICES_DEF,
  parameter int BUFFER_LENGTH = sva_pkg::BUFFER_LENGTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sva_pkg::CMD_W-1:0]         command_i,
  input  logic [sva_pkg::NOTE_W-1:0]        note_number_i,
  input  logic [sva_pkg::PITCH_W-1:0]       pitch_i,
  input  logic [sva_pkg::POS_W-1:0]         start_position_i,
  input  logic [sva_pkg::POS_W-1:0]         sample_position_i,
  input  logic [sva_pkg::ENDED_W-1:0]       ended_voice_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              granted_o,
  output logic [sva_pkg::VIDX_W-1:0]        voice_index_o,
  output logic                              stolen_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sva_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sva_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import sva_pkg::*;

  localparam int CW = $clog2(MAX_VOICES + 1);
  localparam int UW = (CW > USE_W) ? CW : USE_W;
  localparam int IW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  // Configuration registers.
  logic [POLICY_W-1:0] policy_q;
  logic [USE_W-1:0]    use_q;
  logic                release_q;
  logic                cfg_xfer;
  logic                clear_flags;

  // Latched command.
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [NOTE_W-1:0]  note_q, note_d;
  logic [PITCH_W-1:0] pitch_q, pitch_d;
  logic [POS_W-1:0]   start_q, start_d;
  logic [POS_W-1:0]   pos_q, pos_d;

  // Voice flags and record memory.
  logic [MAX_VOICES-1:0] active_q, active_d;
  logic [MAX_VOICES-1:0] cued_q, cued_d;
  voice_rec_t            mem_q [MAX_VOICES];
  voice_rec_t            rd_data_q;
  voice_rec_t            mem_wdata;
  logic [IW-1:0]         mem_waddr;
  logic                  mem_we;
  logic                  mem_re;

  // Scan pipeline.
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rv_q, rv_d;
  logic [IW-1:0] ridx_q, ridx_d;
  logic [UW-1:0] use_ext;
  logic [UW-1:0] n_use;
  logic          issue;

  // Note-on search.
  logic             found_q, found_d;
  logic [IW-1:0]    free_idx_q, free_idx_d;
  logic [IW-1:0]    best_idx_q, best_idx_d;
  logic [AGE_W-1:0] best_key_q, best_key_d;
  logic [AGE_W-1:0] cand_key;
  logic             cand_better;

  // Tick handling.
  logic pos_ok;
  logic start_hit;
  logic act_new;
  logic [IW-1:0] end_idx;

  // Result and output registers.
  logic              res_grant_q, res_grant_d;
  logic [IW-1:0]     res_idx_q, res_idx_d;
  logic              res_stolen_q, res_stolen_d;
  logic              out_valid_q, out_valid_d;
  logic              granted_q, granted_d;
  logic [VIDX_W-1:0] vidx_q, vidx_d;
  logic              stolen_q, stolen_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i & cfg_ready_o;
  assign clear_flags = cfg_xfer && (cfg_index_i == CFG_VOICES_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= POL_STEAL_OLDEST;
      use_q     <= USE_W'(4);
      release_q <= 1'b0;
    end else if (cfg_xfer) begin
      unique case (cfg_index_i)
        CFG_VOICE_POLICY:    policy_q  <= cfg_data_i[POLICY_W-1:0];
        CFG_VOICES_IN_USE:   use_q     <= cfg_data_i[USE_W-1:0];
        CFG_RELEASE_IS_ZERO: release_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A voice count above the table size acts as the table size.
  assign use_ext = UW'(use_q);
  assign n_use   = (use_ext > UW'(MAX_VOICES)) ? UW'(MAX_VOICES) : use_ext;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign granted_o     = granted_q;
  assign voice_index_o = vidx_q;
  assign stolen_o      = stolen_q;

  assign issue    = (state_q == ST_SCAN) && (UW'(cnt_q) < n_use);
  assign mem_re   = issue;
  assign end_idx  = IW'(ended_voice_i);
  assign pos_ok   = {1'b0, pos_q} < BUF_CMP_W'(BUFFER_LENGTH);
  assign start_hit = cued_q[ridx_q] && pos_ok && (rd_data_q.start == pos_q);
  assign act_new   = active_q[ridx_q] | start_hit;

  // The one compare unit ranks candidates by pitch or by age.
  assign cand_key = ((policy_q == POL_STEAL_LOWEST) || (policy_q == POL_STEAL_HIGHEST))
                    ? AGE_W'(rd_data_q.pitch) : rd_data_q.age;
  assign cand_better = (policy_q == POL_STEAL_LOWEST) ? (cand_key < best_key_q)
                                                      : (cand_key > best_key_q);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    note_d       = note_q;
    pitch_d      = pitch_q;
    start_d      = start_q;
    pos_d        = pos_q;
    active_d     = active_q;
    cued_d       = cued_q;
    cnt_d        = cnt_q;
    rv_d         = 1'b0;
    ridx_d       = ridx_q;
    found_d      = found_q;
    free_idx_d   = free_idx_q;
    best_idx_d   = best_idx_q;
    best_key_d   = best_key_q;
    res_grant_d  = res_grant_q;
    res_idx_d    = res_idx_q;
    res_stolen_d = res_stolen_q;
    mem_we       = 1'b0;
    mem_waddr    = ridx_q;
    mem_wdata    = rd_data_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    granted_d    = granted_q;
    vidx_d       = vidx_q;
    stolen_d     = stolen_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = command_i;
          note_d       = note_number_i;
          pitch_d      = pitch_i;
          start_d      = start_position_i;
          pos_d        = sample_position_i;
          cnt_d        = '0;
          found_d      = 1'b0;
          res_grant_d  = 1'b0;
          res_idx_d    = '0;
          res_stolen_d = 1'b0;
          priority if (command_i == CMD_VOICE_ENDED) begin
            if ((UW'(ended_voice_i) < n_use) && active_q[end_idx]) begin
              active_d[end_idx] = 1'b0;
            end
            state_d = ST_FINISH;
          end else if ((command_i == CMD_NOTE_ON) && (n_use == '0)) begin
            state_d = ST_FINISH;
          end else if ((command_i == CMD_NOTE_OFF) && !release_q) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (issue) begin
          cnt_d  = cnt_q + CW'(1);
          rv_d   = 1'b1;
          ridx_d = cnt_q[IW-1:0];
        end
        if (rv_q) begin
          unique case (cmd_q)
            CMD_NOTE_ON: begin
              if (!found_q && !active_q[ridx_q] && !cued_q[ridx_q]) begin
                found_d    = 1'b1;
                free_idx_d = ridx_q;
              end
              if ((ridx_q == '0) || cand_better) begin
                best_idx_d = ridx_q;
                best_key_d = cand_key;
              end
            end
            CMD_NOTE_OFF: begin
              if (active_q[ridx_q] && (rd_data_q.note == note_q)) begin
                active_d[ridx_q] = 1'b0;
              end
            end
            CMD_SAMPLE_TICK: begin
              if (start_hit) begin
                active_d[ridx_q] = 1'b1;
                cued_d[ridx_q]   = 1'b0;
              end
              if (act_new && (rd_data_q.age != '1)) begin
                mem_we        = 1'b1;
                mem_wdata.age = rd_data_q.age + AGE_W'(1);
              end
            end
            default: ;
          endcase
        end
        if (!issue && !rv_q) begin
          state_d = (cmd_q == CMD_NOTE_ON) ? ST_COMMIT : ST_FINISH;
        end
      end

      ST_COMMIT: begin
        priority if (found_q) begin
          res_grant_d = 1'b1;
          res_idx_d   = free_idx_q;
        end else if (policy_q != POL_DROP) begin
          res_grant_d  = 1'b1;
          res_idx_d    = best_idx_q;
          res_stolen_d = 1'b1;
        end else begin
          res_grant_d = 1'b0;
        end
        if (res_grant_d) begin
          mem_we          = 1'b1;
          mem_waddr       = res_idx_d;
          mem_wdata.note  = note_q;
          mem_wdata.pitch = pitch_q;
          mem_wdata.start = start_q;
          mem_wdata.age   = '0;
          active_d[res_idx_d] = 1'b0;
          cued_d[res_idx_d]   = 1'b1;
        end
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          granted_d   = res_grant_q;
          vidx_d      = res_grant_q ? VIDX_W'(res_idx_q) : '0;
          stolen_d    = res_stolen_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (clear_flags) begin
      active_d = '0;
      cued_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      cued_q      <= '0;
      rv_q        <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      cued_q      <= cued_d;
      rv_q        <= rv_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    note_q       <= note_d;
    pitch_q      <= pitch_d;
    start_q      <= start_d;
    pos_q        <= pos_d;
    ridx_q       <= ridx_d;
    found_q      <= found_d;
    free_idx_q   <= free_idx_d;
    best_idx_q   <= best_idx_d;
    best_key_q   <= best_key_d;
    res_grant_q  <= res_grant_d;
    res_idx_q    <= res_idx_d;
    res_stolen_q <= res_stolen_d;
    granted_q    <= granted_d;
    vidx_q       <= vidx_d;
    stolen_q     <= stolen_d;
  end

  // Voice record memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem_q[cnt_q[IW-1:0]];
    end
  end

endmodule
